/* src/assert_macros.svh */
// assertion macros shared by the rtl of the bitrate histogram
// depends on nothing; included by wbh_engine, which checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge out of reset
`define WBH_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("wbh assertion failed");

// same-cycle implication
`define WBH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wbh assertion failed");

// next-cycle implication
`define WBH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wbh assertion failed");

`endif

/* src/wbh_pkg.sv */
// types and constants of the windowed bitrate histogram
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package wbh_pkg;

  localparam int NUM_BUCKETS_DEF = 100;
  localparam int INTERVAL_MS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int BKT_W   = 48;
  localparam int TS_W    = 64;
  localparam int ADD_W   = 32;
  localparam int RATE_W  = 64;
  // bucket bits times 1000 fits here (1000 < 2**10)
  localparam int PROD_W  = BKT_W + 10;
  localparam logic [9:0] MS_PER_S = 10'd1000;
  localparam logic [TS_W-1:0] NS_IN_MS = 64'd1000000;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TIME   = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [TS_W-1:0] now_ns;
    logic [ADD_W-1:0] bits;
  } wbh_item_t;

  typedef struct packed {
    logic init_done;
  } wbh_status_t;

endpackage

/* src/wbh_ifs.sv */
// valid/ready channel interfaces for input items and result items
// depends on nothing
`timescale 1ns / 1ps
interface wbh_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] now_ns;
  logic [31:0] bits;
  modport source (output valid, output operation, output now_ns, output bits, input ready);
  modport sink   (input valid, input operation, input now_ns, input bits, output ready);
endinterface

interface wbh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] min_bps;
  logic [63:0] max_bps;
  logic [63:0] p99_bps;
  modport source (output valid, output min_bps, output max_bps, output p99_bps, input ready);
  modport sink   (input valid, input min_bps, input max_bps, input p99_bps, output ready);
endinterface

/* src/wbh_queue.sv */
// front part: small input queue that takes transactions while the engine works
// depends on wbh_pkg
`timescale 1ns / 1ps
module wbh_queue
  import wbh_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  wbh_item_t   push_item,
  output logic        full,
  input  logic        pop,
  output logic        avail,
  output wbh_item_t   head
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wbh_item_t       slot_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) return '0;
    return p + AW'(1);
  endfunction

  assign full  = (cnt_r == CW'(DEPTH));
  assign avail = (cnt_r != '0);
  assign head  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? bump(wp_r) : wp_r;
    rp_nxt  = pop ? bump(rp_r) : rp_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end
endmodule

/* src/wbh_engine.sv */
// back part: bucket ring memory, time advance, metric scan and result register
// depends on wbh_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wbh_engine
  import wbh_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int INTERVAL_MS = INTERVAL_MS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_avail,
  input  wbh_item_t         q_head,
  output logic              q_pop,
  output wbh_status_t       status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RATE_W-1:0] out_min,
  output logic [RATE_W-1:0] out_max,
  output logic [RATE_W-1:0] out_p99
);
  localparam int PW    = $clog2(NUM_BUCKETS);
  localparam int DVS_W = $clog2(INTERVAL_MS + 1);
  localparam int DIG_W  = 8;
  localparam int NDIG   = (PROD_W + DIG_W - 1) / DIG_W;
  localparam int NUMP_W = NDIG * DIG_W;
  localparam int XW     = DVS_W + DIG_W;
  localparam int SH     = XW + $clog2(INTERVAL_MS);
  localparam int DCW   = $clog2(NDIG);
  localparam logic [TS_W-1:0] INTERVAL_NS  = TS_W'(INTERVAL_MS) * NS_IN_MS;
  localparam logic [TS_W-1:0] INTERVAL2_NS = INTERVAL_NS * 64'd2;
  localparam logic [TS_W-1:0] WINDOW_NS    = INTERVAL_NS * TS_W'(NUM_BUCKETS);
  localparam logic [DVS_W-1:0] DIVISOR     = DVS_W'(INTERVAL_MS);
  localparam logic [PW-1:0] LAST_IDX       = PW'(NUM_BUCKETS - 1);
  // rounded-up reciprocal, exact for every partial dividend below INTERVAL_MS * 256
  localparam logic [SH:0] RECIP =
    (SH+1)'(((64'd1 << SH) + 64'(INTERVAL_MS - 1)) / 64'(INTERVAL_MS));

  typedef enum logic [12:0] {
    S_INIT = 13'b0000000000001,
    S_IDLE = 13'b0000000000010,
    S_CHK  = 13'b0000000000100,
    S_ADV  = 13'b0000000001000,
    S_CLR  = 13'b0000000010000,
    S_SCAN = 13'b0000000100000,
    S_LAST = 13'b0000001000000,
    S_MUL  = 13'b0000010000000,
    S_DIV  = 13'b0000100000000,
    S_HOLD = 13'b0001000000000,
    S_RD   = 13'b0010000000000,
    S_WR   = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [PW-1:0]     ptr_r, ptr_nxt, cnt_r, cnt_nxt, ptr_inc;
  logic [TS_W-1:0]   start_r, start_nxt, elapsed_r, elapsed_nxt, diff;
  logic              started_r, started_nxt;
  logic              op_r;
  logic [TS_W-1:0]   now_r;
  logic [ADD_W-1:0]  bits_r;
  logic              rd_pend_r;
  logic [BKT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, sec_r, sec_nxt;
  logic [NUMP_W-1:0] num_r [3];
  logic [NUMP_W-1:0] num_nxt [3];
  logic [DVS_W-1:0]  rem_r [3];
  logic [DVS_W-1:0]  rem_nxt [3];
  logic [XW-1:0]     dx [3];
  logic [XW+SH:0]    dprod [3];
  logic [DIG_W-1:0]  dq [3];
  logic [DCW-1:0]    dcnt_r, dcnt_nxt;
  logic [RATE_W-1:0] hmin_r, hmin_nxt, hmax_r, hmax_nxt, hsec_r, hsec_nxt;
  logic              ovld_r, ovld_nxt;
  logic [RATE_W-1:0] omin_r, omax_r, osec_r;
  logic              out_load;

  // bucket ring memory
  logic [BKT_W-1:0]  mem [NUM_BUCKETS];
  logic [BKT_W-1:0]  mem_q, wdata;
  logic [PW-1:0]     waddr, raddr;
  logic              we;
  logic [BKT_W:0]    sum;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  assign ptr_inc = (ptr_r == LAST_IDX) ? '0 : ptr_r + PW'(1);
  assign diff    = now_r - start_r;
  assign sum     = {1'b0, mem_q} + (BKT_W + 1)'(bits_r);
  assign out_load = (state_r == S_OUT) && (!ovld_r || out_ready);

  assign q_pop  = (state_r == S_IDLE) && q_avail;
  assign status.init_done = (state_r != S_INIT);

  always_comb begin
    we    = 1'b0;
    waddr = cnt_r;
    wdata = '0;
    raddr = ptr_r;
    case (state_r)
      S_INIT, S_CLR: we = 1'b1;
      S_ADV: begin
        we    = 1'b1;
        waddr = ptr_inc;
      end
      S_SCAN: raddr = cnt_r;
      S_WR: begin
        we    = 1'b1;
        waddr = ptr_r;
        wdata = sum[BKT_W] ? {BKT_W{1'b1}} : sum[BKT_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx[i]      = {rem_r[i], num_r[i][NUMP_W-1 -: DIG_W]};
      dprod[i]   = (XW+SH+1)'(dx[i]) * (XW+SH+1)'(RECIP);
      dq[i]      = dprod[i][SH +: DIG_W];
      num_nxt[i] = num_r[i];
      rem_nxt[i] = rem_r[i];
    end
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    cnt_nxt     = cnt_r;
    start_nxt   = start_r;
    elapsed_nxt = elapsed_r;
    started_nxt = started_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    sec_nxt     = sec_r;
    dcnt_nxt    = dcnt_r;
    hmin_nxt    = hmin_r;
    hmax_nxt    = hmax_r;
    hsec_nxt    = hsec_r;
    ovld_nxt    = ovld_r && !out_ready;

    // fold the bucket read issued last cycle into min, max and second max
    if (rd_pend_r) begin
      if (mem_q < lo_r) lo_nxt = mem_q;
      if (mem_q > hi_r) begin
        sec_nxt = hi_r;
        hi_nxt  = mem_q;
      end else if (mem_q > sec_r) begin
        sec_nxt = mem_q;
      end
    end

    case (state_r)
      S_INIT: begin
        cnt_nxt = cnt_r + PW'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: if (q_avail) state_nxt = S_CHK;
      S_CHK: begin
        lo_nxt  = {BKT_W{1'b1}};
        hi_nxt  = '0;
        sec_nxt = '0;
        cnt_nxt = '0;
        state_nxt = (op_r == OP_TIME) ? S_OUT : S_RD;
        if (op_r == OP_PACKET && !started_r) begin
          started_nxt = 1'b1;
          start_nxt   = now_r;
          ptr_nxt     = '0;
        end else if (started_r && now_r >= start_r && diff >= INTERVAL_NS) begin
          if (diff >= WINDOW_NS) begin
            ptr_nxt   = '0;
            start_nxt = now_r;
            state_nxt = S_CLR;
          end else begin
            elapsed_nxt = diff;
            state_nxt   = S_ADV;
          end
        end
      end
      S_ADV: begin
        ptr_nxt     = ptr_inc;
        start_nxt   = start_r + INTERVAL_NS;
        elapsed_nxt = elapsed_r - INTERVAL_NS;
        if (elapsed_r < INTERVAL2_NS) state_nxt = S_SCAN;
      end
      S_CLR: begin
        cnt_nxt = cnt_r + PW'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + PW'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_LAST;
        end
      end
      S_LAST: state_nxt = S_MUL;
      S_MUL: begin
        num_nxt[0] = NUMP_W'(lo_r) * NUMP_W'(MS_PER_S);
        num_nxt[1] = NUMP_W'(hi_r) * NUMP_W'(MS_PER_S);
        num_nxt[2] = NUMP_W'(sec_r) * NUMP_W'(MS_PER_S);
        for (int i = 0; i < 3; i++) rem_nxt[i] = '0;
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // long division by the interval length, one byte of quotient per cycle
        for (int i = 0; i < 3; i++) begin
          rem_nxt[i] = DVS_W'(dx[i] - XW'(dq[i]) * XW'(DIVISOR));
          num_nxt[i] = {num_r[i][NUMP_W-DIG_W-1:0], dq[i]};
        end
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(NDIG - 1)) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        hmin_nxt  = RATE_W'(num_r[0]);
        hmax_nxt  = RATE_W'(num_r[1]);
        hsec_nxt  = RATE_W'(num_r[2]);
        state_nxt = (op_r == OP_TIME) ? S_OUT : S_RD;
      end
      S_RD: state_nxt = S_WR;
      S_WR: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      ptr_r     <= '0;
      cnt_r     <= '0;
      start_r   <= '0;
      started_r <= 1'b0;
      rd_pend_r <= 1'b0;
      hmin_r    <= '0;
      hmax_r    <= '0;
      hsec_r    <= '0;
      ovld_r    <= 1'b0;
      dcnt_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      ptr_r     <= ptr_nxt;
      cnt_r     <= cnt_nxt;
      start_r   <= start_nxt;
      started_r <= started_nxt;
      rd_pend_r <= (state_r == S_SCAN);
      hmin_r    <= hmin_nxt;
      hmax_r    <= hmax_nxt;
      hsec_r    <= hsec_nxt;
      ovld_r    <= ovld_nxt;
      dcnt_r    <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    sec_r     <= sec_nxt;
    for (int i = 0; i < 3; i++) begin
      num_r[i] <= num_nxt[i];
      rem_r[i] <= rem_nxt[i];
    end
    if (q_pop) begin
      op_r   <= q_head.operation;
      now_r  <= q_head.now_ns;
      bits_r <= q_head.bits;
    end
    if (out_load) begin
      omin_r <= hmin_r;
      omax_r <= hmax_r;
      osec_r <= hsec_r;
    end
  end

  assign out_valid = ovld_r;
  assign out_min   = omin_r;
  assign out_max   = omax_r;
  assign out_p99   = osec_r;

  `WBH_ASSERT_ALWAYS(a_ptr_range, clk, rst_n, ptr_r <= LAST_IDX)
  `WBH_ASSERT_IMP(a_no_pop_in_init, clk, rst_n, state_r == S_INIT, !q_pop)
  `WBH_ASSERT_NXT(a_result_loaded, clk, rst_n, out_load, ovld_r && state_r == S_IDLE)
  `WBH_ASSERT_IMP(a_max_over_second, clk, rst_n, state_r == S_MUL, hi_r >= sec_r && hi_r >= lo_r)
endmodule

/* src/windowed_bitrate_histogram.sv */
// top level of the windowed bitrate histogram
// depends on wbh_pkg, wbh_ifs, wbh_queue and wbh_engine
`timescale 1ns / 1ps
// usage:
//   in_ch carries packet events (operation 0: now_ns plus bits) and time
//   updates (operation 1: now_ns only). out_ch returns exactly one transaction
//   per input with the held min, max and second-largest bucket rates in bps.
//   an input queue of QUEUE_DEPTH entries takes transactions while the engine
//   works on an earlier one; the engine handles one item at a time.
//   a packet with no interval crossing goes from queue head through the
//   check, a bucket read and a bucket write to the result register; a time
//   update with no crossing goes from the check straight there. an interval
//   crossing adds one step per skipped interval, a metric scan over every
//   bucket through the one read port of the bucket memory, a multiply, a
//   division by INTERVAL_MS one quotient byte at a time and a step to hold
//   the rates. a gap of a whole window adds a clearing pass over all buckets
//   instead of the interval steps. the next item is taken after the last.
//   reset: after rst_n the engine clears the bucket memory, one bucket per
//   cycle; in_ch.ready stays low until that is done.
//   stall: a result waits in the output register; the engine holds the next
//   result until out_ch.ready frees it, and the queue keeps filling meanwhile.
module windowed_bitrate_histogram
  import wbh_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int INTERVAL_MS = INTERVAL_MS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  wbh_in_if.sink     in_ch,
  wbh_out_if.source  out_ch
);
  wbh_item_t   push_item, head;
  wbh_status_t status;
  logic        full, avail, pop, push;

  assign in_ch.ready = !full && status.init_done;
  assign push        = in_ch.valid && in_ch.ready;
  assign push_item.operation = in_ch.operation;
  assign push_item.now_ns    = in_ch.now_ns;
  assign push_item.bits      = in_ch.bits;

  wbh_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .head      (head)
  );

  wbh_engine #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .INTERVAL_MS(INTERVAL_MS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_avail   (avail),
    .q_head    (head),
    .q_pop     (pop),
    .status    (status),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_min   (out_ch.min_bps),
    .out_max   (out_ch.max_bps),
    .out_p99   (out_ch.p99_bps)
  );
endmodule
